/* sv/hbs_pkg.sv */
// types, codes and reset values shared by the histogram binner modules
package hbs_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_OUT_RANGE = 2'd1;
  localparam logic [1:0] STS_BAD_INDEX = 2'd2;

  localparam logic [1:0] CFG_MIN_VALUE   = 2'd0;
  localparam logic [1:0] CFG_BIN_SPAN    = 2'd1;
  localparam logic [1:0] CFG_BINS_IN_USE = 2'd2;

  localparam logic signed [31:0] MIN_VALUE_RST   = 32'sd0;
  localparam logic [30:0]        BIN_SPAN_RST    = 31'd65536;
  localparam logic [8:0]         BINS_IN_USE_RST = 9'd256;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] sample;
    logic [7:0]         read_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  bin;
    logic [31:0] count;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sweep;
    logic check;
    logic update;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic step_last;
    logic sweep_last;
    logic go_mem;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/hbs_ram.sv */
// generic single-write, single-read RAM with registered read data
module hbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/hbs_dp.sv */
// histogram binner datapath: config registers, edge search, count memory, output register
module hbs_dp #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  hbs_pkg::in_word_t in_data,
  input  hbs_pkg::dp_cmd_t  cmd,
  output hbs_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output hbs_pkg::out_word_t out_data
);

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int NB_W  = IDX_W + 1;
  localparam int JW    = $clog2(IDX_W + 1);
  localparam int EW    = IDX_W + 34;

  logic signed [31:0] min_value;
  logic [30:0]        bin_span;
  logic [8:0]         bins_in_use;

  logic [1:0]         op;
  logic signed [31:0] sample;
  logic [7:0]         read_index;
  logic [IDX_W-1:0]   b;
  logic signed [EW-1:0] acc;
  logic [JW-1:0]      j;
  logic [IDX_W-1:0]   sweep;
  hbs_pkg::out_word_t res;

  logic [NB_W-1:0]      n;
  logic [NB_W-1:0]      step_amt;
  logic [NB_W-1:0]      cand;
  logic signed [EW-1:0] s_ext;
  logic signed [EW-1:0] min_ext;
  logic signed [EW-1:0] w_ext;
  logic signed [EW-1:0] probe;
  logic                 take;
  logic                 in_range;
  logic                 read_oob;
  logic                 go_mem;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cnt_inc;

  // effective bin count, capped at the memory depth
  assign n = (32'(bins_in_use) > 32'(MAX_BINS)) ? NB_W'(MAX_BINS) : NB_W'(bins_in_use);

  assign s_ext    = EW'(sample);
  assign min_ext  = EW'(min_value);
  assign w_ext    = EW'(bin_span);
  assign step_amt = NB_W'(1) << j;
  assign cand     = NB_W'(b) + step_amt;
  assign probe    = acc + (w_ext << j);
  assign take     = (cand < n) && (s_ext >= probe);

  assign in_range = (n != '0) && (s_ext >= min_ext) && (s_ext < acc + w_ext);
  assign read_oob = 32'(read_index) >= 32'(n);
  assign go_mem   = (op == hbs_pkg::OP_ADD) ? in_range :
                    (op == hbs_pkg::OP_READ) ? !read_oob : 1'b0;

  assign cnt_inc = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

  assign ram_we    = cmd.sweep || (cmd.update && op == hbs_pkg::OP_ADD);
  assign ram_waddr = cmd.sweep ? sweep : b;
  assign ram_wdata = cmd.sweep ? '0 : cnt_inc;
  assign ram_raddr = (op == hbs_pkg::OP_ADD) ? b : IDX_W'(read_index);

  assign stat.step_last  = (j == '0);
  assign stat.sweep_last = (sweep == IDX_W'(MAX_BINS - 1));
  assign stat.go_mem     = go_mem;
  assign stat.out_free   = !out_valid || out_ready;

  hbs_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_BINS)
  ) u_totals (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value   <= hbs_pkg::MIN_VALUE_RST;
      bin_span    <= hbs_pkg::BIN_SPAN_RST;
      bins_in_use <= hbs_pkg::BINS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbs_pkg::CFG_MIN_VALUE:   min_value   <= cfg_data;
        hbs_pkg::CFG_BIN_SPAN:    bin_span    <= cfg_data[30:0];
        hbs_pkg::CFG_BINS_IN_USE: bins_in_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.load) begin
      sweep <= '0;
    end else if (cmd.sweep) begin
      sweep <= sweep + IDX_W'(1);
    end
  end

  // search state: b is the bin whose lower edge is acc
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= in_data.op;
      sample     <= in_data.sample;
      read_index <= in_data.read_index;
      b          <= '0;
      acc        <= EW'(min_value);
      j          <= JW'(IDX_W - 1);
    end else if (cmd.step) begin
      if (take) begin
        b   <= IDX_W'(cand);
        acc <= probe;
      end
      j <= j - JW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check && !go_mem) begin
      res.bin   <= (op == hbs_pkg::OP_READ) ? read_index : 8'd0;
      res.count <= 32'd0;
      if (op == hbs_pkg::OP_ADD) begin
        res.status <= hbs_pkg::STS_OUT_RANGE;
      end else if (op == hbs_pkg::OP_READ) begin
        res.status <= hbs_pkg::STS_BAD_INDEX;
      end else begin
        res.status <= hbs_pkg::STS_OK;
      end
    end else if (cmd.update) begin
      res.bin    <= (op == hbs_pkg::OP_ADD) ? 8'(b) : read_index;
      res.count  <= (op == hbs_pkg::OP_ADD) ? 32'(cnt_inc) : 32'(ram_rdata);
      res.status <= hbs_pkg::STS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data <= res;
    end
  end

endmodule

/* sv/hbs_ctrl.sv */
// histogram binner controller state machine
module hbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  hbs_pkg::dp_stat_t stat,
  output hbs_pkg::dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SEARCH = 7'b0000100,
    S_CLEAR  = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == hbs_pkg::OP_ADD) begin
            state_next = S_SEARCH;
          end else if (in_op == hbs_pkg::OP_CLEAR) begin
            state_next = S_CLEAR;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_next = S_CHECK;
        end
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.go_mem ? S_READ : S_RESULT;
      end
      S_READ: begin
        cmd.update = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/histogram_binary_search_binner.sv */
// histogram over uniform bins, bin found by binary search over the bin edges
// add: log2(MAX_BINS) search steps, one edge probe per cycle, then a memory read-modify-write;
//   states SEARCH, CHECK, READ, RESULT, with READ skipped out of range; the next word is
//   taken once back in IDLE, and is held off while RESULT waits under output stall
// read: CHECK, READ, RESULT, no READ for a bad index or unused op; clear: sweep, CHECK, RESULT
// reset: sync, active high; then all MAX_BINS counts are zeroed with in_ready low
module histogram_binary_search_binner #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  hbs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hbs_pkg::out_word_t out_data
);

  hbs_pkg::dp_cmd_t  cmd;
  hbs_pkg::dp_stat_t stat;

  hbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_data.op),
    .stat     (stat),
    .cmd      (cmd)
  );

  hbs_dp #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result published over an unread word");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("published result not shown");

  a_idle_only: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!cmd.step && !cmd.sweep && !cmd.update))
    else $error("input taken while an item is in work");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == hbs_pkg::STS_OUT_RANGE) |->
      (out_data.count == 32'd0 && out_data.bin == 8'd0))
    else $error("out of range word carries a count");

endmodule

/* tb/histogram_binary_search_binner_tb.sv */
// testbench for the histogram binner: directed table, then random phases checked by a predictor
module histogram_binary_search_binner_tb;

  localparam int MAX_BINS   = 256;
  localparam int COUNT_BITS = 32;
  localparam int PHASES     = 10;
  localparam int PHASE_WORDS = 128;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         reg_index;
    logic [31:0]        reg_data;
    hbs_pkg::in_word_t  word;
    hbs_pkg::out_word_t want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [33] = '{
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_READ, 32'h0, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OK}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_READ, 32'h0, 8'd255},
      '{8'd255, 32'd0, hbs_pkg::STS_OK}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h0, 8'd0},
      '{8'd0, 32'd1, hbs_pkg::STS_OK}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h0000FFFF, 8'd0},
      '{8'd0, 32'd2, hbs_pkg::STS_OK}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h00010000, 8'd0},
      '{8'd1, 32'd1, hbs_pkg::STS_OK}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'hFFFFFFFF, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OUT_RANGE}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h80000000, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OUT_RANGE}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h7FFFFFFF, 8'hFF},
      '{8'd0, 32'd0, hbs_pkg::STS_OUT_RANGE}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h00FFFFFF, 8'd0},
      '{8'd255, 32'd1, hbs_pkg::STS_OK}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h01000000, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OUT_RANGE}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{OP_UNUSED, 32'hFFFFFFFF, 8'hFF},
      '{8'd0, 32'd0, hbs_pkg::STS_OK}},
    '{ROW_ITEM, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_READ, 32'h0, 8'd1}, '0},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_CLEAR, 32'h0, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OK}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_READ, 32'h0, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OK}},
    // no bins at all
    '{ROW_REG, hbs_pkg::CFG_BINS_IN_USE, 32'd0, '0, '0},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h0, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OUT_RANGE}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_READ, 32'h0, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_BAD_INDEX}},
    // four unit-width bins at the most negative value
    '{ROW_REG, hbs_pkg::CFG_BINS_IN_USE, 32'd4, '0, '0},
    '{ROW_REG, hbs_pkg::CFG_MIN_VALUE, 32'h80000000, '0, '0},
    '{ROW_REG, hbs_pkg::CFG_BIN_SPAN, 32'd1, '0, '0},
    '{ROW_ITEM, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h80000000, 8'd0}, '0},
    '{ROW_ITEM, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h80000003, 8'd0}, '0},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h80000004, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OUT_RANGE}},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_READ, 32'h0, 8'd4},
      '{8'd4, 32'd0, hbs_pkg::STS_BAD_INDEX}},
    '{ROW_ITEM, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_READ, 32'h0, 8'd3}, '0},
    // zero width
    '{ROW_REG, hbs_pkg::CFG_BIN_SPAN, 32'd0, '0, '0},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h80000000, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OUT_RANGE}},
    // bins above the maximum, widest bins at the top value
    '{ROW_REG, hbs_pkg::CFG_BINS_IN_USE, 32'h000001FF, '0, '0},
    '{ROW_REG, hbs_pkg::CFG_BIN_SPAN, 32'h7FFFFFFF, '0, '0},
    '{ROW_REG, hbs_pkg::CFG_MIN_VALUE, 32'h7FFFFFFF, '0, '0},
    '{ROW_ITEM, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h7FFFFFFF, 8'd0}, '0},
    '{ROW_ITEM, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_READ, 32'h0, 8'd255}, '0},
    '{ROW_KNOWN, hbs_pkg::CFG_MIN_VALUE, 32'd0, '{hbs_pkg::OP_ADD, 32'h7FFFFFFE, 8'd0},
      '{8'd0, 32'd0, hbs_pkg::STS_OUT_RANGE}}
  };

  localparam logic [31:0] PHASE_MIN [PHASES] = '{
    32'h0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
    32'hFFF00000, 32'h0, 32'h0, 32'h0, 32'h00010000
  };
  localparam logic [31:0] PHASE_WIDTH [PHASES] = '{
    32'd65536, 32'd1, 32'h7FFFFFFF, 32'h01000000, 32'h7FFFFFFF,
    32'h80000400, 32'h0, 32'h0, 32'h0, 32'h0
  };
  localparam logic [31:0] PHASE_BINS [PHASES] = '{
    32'd256, 32'd1, 32'd2, 32'd256, 32'd256,
    32'hFFFFFE40, 32'h0, 32'h0, 32'h0, 32'd300
  };

  bit                 clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  hbs_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  hbs_pkg::out_word_t out_data;

  logic signed [31:0]    cur_min;
  logic [30:0]           cur_width;
  logic [8:0]            cur_bins;
  logic [COUNT_BITS-1:0] tally [MAX_BINS];
  hbs_pkg::out_word_t    expected_bins [$];
  bit                    no_gaps;
  int                    mismatches;
  int                    cycle_count;

  histogram_binary_search_binner #(
    .MAX_BINS  (MAX_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int live_bins();
    return (int'(cur_bins) > MAX_BINS) ? MAX_BINS : int'(cur_bins);
  endfunction

  function automatic longint bin_edge(int i);
    return longint'(cur_min) + longint'(i + 1) * longint'({1'b0, cur_width});
  endfunction

  function automatic int find_bin(longint s, int n);
    int     lo;
    int     hi;
    int     mid;
    longint top;
    longint bottom;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      top = bin_edge(mid);
      bottom = (mid == 0) ? longint'(cur_min) : bin_edge(mid - 1);
      if (s >= top) lo = mid + 1;
      else if (s < bottom) hi = mid - 1;
      else return mid;
    end
    return -1;
  endfunction

  function automatic hbs_pkg::out_word_t predict_bin_result(hbs_pkg::in_word_t w);
    hbs_pkg::out_word_t r;
    int                 n;
    int                 b;
    r = '0;
    n = live_bins();
    unique case (w.op)
      hbs_pkg::OP_ADD: begin
        b = find_bin(longint'(w.sample), n);
        if (b < 0) begin
          r.status = hbs_pkg::STS_OUT_RANGE;
        end else begin
          if (tally[b] != '1) tally[b]++;
          r.bin = b[7:0];
          r.count = tally[b];
        end
      end
      hbs_pkg::OP_READ: begin
        r.bin = w.read_index;
        if (int'(w.read_index) >= n) r.status = hbs_pkg::STS_BAD_INDEX;
        else r.count = tally[w.read_index];
      end
      hbs_pkg::OP_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_sample(int n);
    longint v;
    int     r;
    int     b;
    r = $urandom_range(0, 99);
    v = longint'($signed($urandom));
    if (n > 0 && cur_width != 0 && r < 85) begin
      if (r < 65) begin
        b = $urandom_range(0, n - 1);
        v = bin_edge(b - 1) + longint'({32'd0, $urandom % {1'b0, cur_width}});
      end else begin
        // around a bin edge, lowest and highest included
        b = $urandom_range(0, n);
        v = bin_edge(b - 1) + longint'($urandom_range(0, 2)) - 1;
      end
      if (v != longint'($signed(v[31:0]))) v = longint'($signed($urandom));
    end
    return v[31:0];
  endfunction

  function automatic hbs_pkg::in_word_t pick_word();
    hbs_pkg::in_word_t w;
    int                r;
    int                n;
    n = live_bins();
    r = $urandom_range(0, 99);
    w.sample = pick_sample(n);
    w.read_index = 8'($urandom);
    if (r < 72) begin
      w.op = hbs_pkg::OP_ADD;
    end else if (r < 94) begin
      w.op = hbs_pkg::OP_READ;
      if (n > 0 && $urandom_range(0, 4) != 0) w.read_index = 8'($urandom_range(0, n - 1));
    end else if (r < 97) begin
      w.op = OP_UNUSED;
    end else begin
      w.op = hbs_pkg::OP_CLEAR;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic offer(hbs_pkg::in_word_t w, bit known, hbs_pkg::out_word_t want);
    hbs_pkg::out_word_t predicted;
    int                 gap;
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = predict_bin_result(w);
    expected_bins.push_back(known ? want : predicted);
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    unique case (idx)
      hbs_pkg::CFG_MIN_VALUE:   cur_min = data;
      hbs_pkg::CFG_BIN_SPAN:    cur_width = data[30:0];
      hbs_pkg::CFG_BINS_IN_USE: cur_bins = data[8:0];
      default: ;
    endcase
  endtask

  // result side: random stalls, one long hold-off, in-order check
  initial begin
    int                 stall_left;
    bit                 held_off;
    int                 words_seen;
    hbs_pkg::out_word_t want;
    stall_left = 0;
    held_off = 0;
    words_seen = 0;
    out_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(negedge clk);
      if (!held_off && words_seen >= 300) begin
        held_off = 1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_bins.size() == 0) begin
          report_mismatch("unexpected word", longint'(out_data), 0);
        end else begin
          want = expected_bins.pop_front();
          if (out_data.bin !== want.bin) report_mismatch("bin", out_data.bin, want.bin);
          if (out_data.count !== want.count) report_mismatch("count", out_data.count, want.count);
          if (out_data.status !== want.status) begin
            report_mismatch("status", out_data.status, want.status);
          end
        end
      end
    end
  end

  initial begin
    bit          regs_open;
    logic [31:0] min_w;
    logic [31:0] width_w;
    logic [31:0] bins_w;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = hbs_pkg::CFG_MIN_VALUE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    no_gaps = 0;
    regs_open = 0;
    cur_min = hbs_pkg::MIN_VALUE_RST;
    cur_width = hbs_pkg::BIN_SPAN_RST;
    cur_bins = hbs_pkg::BINS_IN_USE_RST;
    foreach (tally[i]) tally[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        if (!regs_open) drain_and_settle();
        regs_open = 1;
        write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_data);
      end else begin
        regs_open = 0;
        offer(DIRECTED[i].word, DIRECTED[i].kind == ROW_KNOWN, DIRECTED[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      min_w = PHASE_MIN[p];
      width_w = PHASE_WIDTH[p];
      bins_w = PHASE_BINS[p];
      if (p >= 6 && p <= 8) begin
        min_w = $urandom;
        width_w = $urandom_range(1, 32'h00040000) | ($urandom & 32'h80000000);
        bins_w = $urandom_range(1, 511);
      end
      drain_and_settle();
      no_gaps = (p == 2 || p == 7);
      write_reg(hbs_pkg::CFG_MIN_VALUE, min_w);
      write_reg(hbs_pkg::CFG_BIN_SPAN, width_w);
      write_reg(hbs_pkg::CFG_BINS_IN_USE, bins_w);
      repeat (PHASE_WORDS) offer(pick_word(), 1'b0, '0);
    end

    drain_and_settle();
    repeat (MAX_BINS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
